// ===== design/ulnrc_pkg.sv =====
package ulnrc_pkg;

	// Default store depths
	localparam int LINE_DEPTH_DEF     = 128;
	localparam int SENTENCE_DEPTH_DEF = 128;

	// Field widths of the request and result items
	localparam int KIND_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 7;
	localparam int COUNT_W = 7;
	localparam int LEN_W   = 8;

	// Characters with a meaning to the assemblers
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;

	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE      = 3'd0,
		KIND_READ_LINE = 3'd1,
		KIND_READ_SENT = 3'd2,
		KIND_TAKE      = 3'd3,
		KIND_ACK       = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] rx_byte;
		logic [IDX_W-1:0]  index;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic               line_ready;
		logic [COUNT_W-1:0] line_count;
		logic [COUNT_W-1:0] taken_count;
		logic               sentence_ready;
		logic [LEN_W-1:0]   sentence_length;
	} out_item_t;

	// Request handed to both store units
	typedef struct packed {
		logic              start;
		kind_t             kind;
		logic [BYTE_W-1:0] rx_byte;
		logic [IDX_W-1:0]  index;
	} unit_req_t;

	typedef struct packed {
		logic               busy;
		logic [BYTE_W-1:0]  data_byte;
		logic               line_ready;
		logic [COUNT_W-1:0] line_count;
		logic [COUNT_W-1:0] taken_count;
	} line_stat_t;

	typedef struct packed {
		logic              busy;
		logic [BYTE_W-1:0] data_byte;
		logic              sentence_ready;
		logic [LEN_W-1:0]  sentence_length;
	} sent_stat_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_ADDR,
		L_EXEC,
		L_FIX,
		L_CLR
	} line_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_EXEC
	} sent_state_t;

	typedef enum logic {
		T_IDLE,
		T_WAIT
	} top_state_t;

endpackage

// ===== design/ulnrc_stream_if.sv =====
interface ulnrc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/ulnrc_line_store.sv =====
module ulnrc_line_store #(
	parameter int DEPTH = ulnrc_pkg::LINE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ulnrc_pkg::unit_req_t  req,
	output ulnrc_pkg::line_stat_t stat
);
	import ulnrc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int HW_W = AW + 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	line_state_t state_q, state_d;

	logic [BYTE_W-1:0] line_mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [AW-1:0]     fill_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     fix_addr_q;
	logic [HW_W-1:0]   hw_q;
	logic              flag_q;
	logic [BYTE_W-1:0] e0_q;
	logic [BYTE_W-1:0] data_q;
	logic [AW-1:0]     taken_q;

	kind_t             kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  idx_q;

	logic              we;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              prev_cr;
	logic [BYTE_W-1:0] e0_after;
	logic [AW-1:0]     fill_step;
	logic [HW_W-1:0]   written_top;
	logic              idx_hit;

	// Entry before the write position, read in the address cycle
	assign prev_cr     = (rd_data_q == CH_CR);
	assign e0_after    = (we && wr_addr == '0) ? wr_data : e0_q;
	assign fill_step   = (fill_q == LAST) ? '0 : fill_q + AW'(1);
	assign written_top = {1'b0, fill_q} + HW_W'(1);
	// Entries above the high-water mark were never written since reset
	assign idx_hit     = (32'(idx_q) < 32'(hw_q));
	assign rd_addr     = (kind_q == KIND_BYTE) ? fill_q - AW'(1) : AW'(idx_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE: if (req.start) state_d = L_ADDR;
			L_ADDR: state_d = L_EXEC;
			L_EXEC: begin
				state_d = L_IDLE;
				case (kind_q)
					KIND_BYTE: begin
						if (byte_q == CH_LF && fill_q != '0 && prev_cr) state_d = L_FIX;
					end
					KIND_TAKE: begin
						if (flag_q && fill_q != '0) state_d = L_CLR;
					end
					default: ;
				endcase
			end
			L_FIX: state_d = L_IDLE;
			L_CLR: if (clr_q == fill_q - AW'(1)) state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	// Memory write port control
	always_comb begin
		we      = 1'b0;
		wr_addr = fill_q;
		wr_data = byte_q;
		case (state_q)
			L_EXEC: begin
				if (kind_q == KIND_BYTE) begin
					we = 1'b1;
					// Newline: blank a CR just before it, else blank the newline itself
					if (byte_q == CH_LF) begin
						wr_data = '0;
						if (fill_q != '0 && prev_cr) wr_addr = fill_q - AW'(1);
					end
				end
			end
			L_FIX: begin
				we      = 1'b1;
				wr_addr = fix_addr_q;
				wr_data = CH_LF;
			end
			L_CLR: begin
				we      = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			default: ;
		endcase
	end

	// Line memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) line_mem[wr_addr] <= wr_data;
		rd_data_q <= line_mem[rd_addr];
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && req.start) begin
			kind_q <= req.kind;
			byte_q <= req.rx_byte;
			idx_q  <= req.index;
		end
		if (state_q == L_EXEC) fix_addr_q <= fill_q;
	end

	// Fill, high-water mark, flag, read data, taken count and entry-zero shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			fill_q  <= '0;
			clr_q   <= '0;
			hw_q    <= '0;
			flag_q  <= 1'b0;
			e0_q    <= '0;
			data_q  <= '0;
			taken_q <= '0;
		end else begin
			state_q <= state_d;
			if (we && wr_addr == '0) e0_q <= wr_data;
			if (state_q == L_IDLE && req.start) begin
				data_q  <= '0;
				taken_q <= '0;
				clr_q   <= '0;
			end
			if (state_q == L_EXEC) begin
				case (kind_q)
					KIND_BYTE: begin
						if (written_top > hw_q) hw_q <= written_top;
						if (byte_q == CH_BS) begin
							fill_q <= (fill_q != '0) ? fill_q - AW'(1) : '0;
						end else begin
							fill_q <= fill_step;
						end
						if (byte_q == CH_LF && e0_after != '0) flag_q <= 1'b1;
					end
					KIND_READ_LINE: begin
						data_q <= idx_hit ? rd_data_q : '0;
					end
					KIND_TAKE: begin
						if (flag_q) begin
							taken_q <= fill_q;
							if (fill_q == '0) flag_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			// Clear the taken line one entry a cycle
			if (state_q == L_CLR) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == fill_q - AW'(1)) begin
					fill_q <= '0;
					flag_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy        = (state_q != L_IDLE);
	assign stat.data_byte   = data_q;
	assign stat.line_ready  = flag_q;
	assign stat.line_count  = COUNT_W'(fill_q);
	assign stat.taken_count = COUNT_W'(taken_q);

	a_fill_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} <= hw_q)
		else $error("line fill above high-water mark");

	a_clear_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == L_CLR |-> flag_q && clr_q < fill_q)
		else $error("line clear sweep outside taken line");

endmodule

// ===== design/ulnrc_sentence_store.sv =====
module ulnrc_sentence_store #(
	parameter int DEPTH = ulnrc_pkg::SENTENCE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ulnrc_pkg::unit_req_t  req,
	output ulnrc_pkg::sent_stat_t stat
);
	import ulnrc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int MEM_DEPTH = 2 ** (AW + 1);
	localparam logic [FW-1:0] FULL = FW'(DEPTH);

	sent_state_t state_q, state_d;

	// Two banks: one fills, the other holds the saved sentence
	logic [BYTE_W-1:0] sent_mem [MEM_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     saved_len_q;
	logic              saved_flag_q;
	logic              sbank_q;
	logic [BYTE_W-1:0] sh0_q;
	logic [BYTE_W-1:0] sh4_q;
	logic [BYTE_W-1:0] sh5_q;
	logic [BYTE_W-1:0] data_q;

	kind_t             kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  idx_q;

	logic              we;
	logic [AW:0]       wr_addr;
	logic [AW:0]       rd_addr;
	logic [FW-1:0]     f1;
	logic [FW-1:0]     f2;
	logic              room;
	logic [BYTE_W-1:0] sh0_n;
	logic [BYTE_W-1:0] sh4_n;
	logic [BYTE_W-1:0] sh5_n;
	logic              save;
	logic              idx_hit;

	// Fill position after a possible restart, and the drop when full
	assign f1   = (byte_q == CH_DOLLAR) ? '0 : fill_q;
	assign room = (f1 < FULL);
	assign f2   = room ? f1 + FW'(1) : f1;

	// Shadows of the tested entries, with this byte forwarded
	assign sh0_n = (room && f1 == FW'(0)) ? byte_q : sh0_q;
	assign sh4_n = (room && f1 == FW'(4)) ? byte_q : sh4_q;
	assign sh5_n = (room && f1 == FW'(5)) ? byte_q : sh5_q;
	assign save  = (byte_q == CH_LF) && (sh0_n == CH_DOLLAR) && (sh4_n == CH_M) &&
		(sh5_n == CH_C);

	// Saved bank reads zero past the saved length
	assign idx_hit = (32'(idx_q) < 32'(saved_len_q));
	assign wr_addr = {~sbank_q, AW'(f1)};
	assign rd_addr = {sbank_q, AW'(idx_q)};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.start) state_d = S_ADDR;
			S_ADDR: state_d = S_EXEC;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory write enable
	always_comb begin
		we = 1'b0;
		case (state_q)
			S_EXEC: we = (kind_q == KIND_BYTE) && room;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) sent_mem[wr_addr] <= byte_q;
		rd_data_q <= sent_mem[rd_addr];
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.start) begin
			kind_q <= req.kind;
			byte_q <= req.rx_byte;
			idx_q  <= req.index;
		end
	end

	// Fill, bank swap on a complete RMC sentence, acknowledge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			saved_len_q  <= '0;
			saved_flag_q <= 1'b0;
			sbank_q      <= 1'b0;
			sh0_q        <= '0;
			sh4_q        <= '0;
			sh5_q        <= '0;
			data_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req.start) data_q <= '0;
			if (state_q == S_EXEC) begin
				case (kind_q)
					KIND_BYTE: begin
						if (save) begin
							sbank_q      <= ~sbank_q;
							saved_len_q  <= f2;
							saved_flag_q <= 1'b1;
							fill_q       <= '0;
							sh0_q        <= '0;
							sh4_q        <= '0;
							sh5_q        <= '0;
						end else begin
							fill_q <= f2;
							sh0_q  <= sh0_n;
							sh4_q  <= sh4_n;
							sh5_q  <= sh5_n;
						end
					end
					KIND_READ_SENT: begin
						data_q <= idx_hit ? rd_data_q : '0;
					end
					KIND_ACK: begin
						saved_flag_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.busy            = (state_q != S_IDLE);
	assign stat.data_byte       = data_q;
	assign stat.sentence_ready  = saved_flag_q;
	assign stat.sentence_length = LEN_W'(saved_len_q);

	a_counts_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL && saved_len_q <= FULL)
		else $error("sentence count beyond store depth");

	a_save_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(saved_flag_q) |-> fill_q == '0 && sh0_q == '0 && saved_len_q != '0)
		else $error("sentence save left fill or shadows behind");

endmodule

// ===== design/uart_line_and_nmea_rmc_capture.sv =====
// Receive-side text assembler: each request carries a received UART byte or a
// command (read a line entry, read a saved sentence entry, take the line,
// acknowledge the sentence) and produces exactly one result with the status
// after the request. Bytes feed an editable line store and an NMEA RMC capture
// side by side. A request passes an address state, then an execute state, in
// the read-then-write sequence on the single-port-per-direction memories; a
// newline that blanks a preceding CR adds a fix state, and taking a ready
// line adds a clearing pass, one memory write per cleared entry. The next
// request is taken as soon as the result is registered, even if it has not
// been collected yet. The memories are not cleared at reset: line entries
// above the high-water mark and saved entries past the saved length read as
// zero, so no clearing pass follows reset.
module uart_line_and_nmea_rmc_capture #(
	parameter int LINE_DEPTH     = ulnrc_pkg::LINE_DEPTH_DEF,
	parameter int SENTENCE_DEPTH = ulnrc_pkg::SENTENCE_DEPTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	ulnrc_stream_if.sink    item,
	ulnrc_stream_if.source  result
);
	import ulnrc_pkg::*;

	top_state_t state_q, state_d;

	in_item_t   in_item;
	unit_req_t  unit_req;
	line_stat_t line_stat;
	sent_stat_t sent_stat;

	logic       accept;
	logic       units_idle;
	logic       slot_free;
	logic       load;
	logic       out_valid_q;
	out_item_t  out_q;

	assign in_item    = item.payload;
	assign accept     = item.valid && item.ready;
	assign units_idle = !line_stat.busy && !sent_stat.busy;
	assign slot_free  = !out_valid_q || result.ready;

	// Start both units on every accepted request
	assign unit_req = '{
		start:   accept,
		kind:    kind_t'(in_item.kind),
		rx_byte: in_item.rx_byte,
		index:   in_item.index
	};

	ulnrc_line_store #(
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.stat   (line_stat)
	);

	ulnrc_sentence_store #(
		.DEPTH (SENTENCE_DEPTH)
	) u_sent (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.stat   (sent_stat)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: if (accept) state_d = T_WAIT;
			T_WAIT: if (units_idle && slot_free) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// Handshake and result load
	always_comb begin
		item.ready = 1'b0;
		load       = 1'b0;
		case (state_q)
			T_IDLE: item.ready = 1'b1;
			T_WAIT: load = units_idle && slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until the sink takes it; units zero unused read data
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.data_byte       <= line_stat.data_byte | sent_stat.data_byte;
			out_q.line_ready      <= line_stat.line_ready;
			out_q.line_count      <= line_stat.line_count;
			out_q.taken_count     <= line_stat.taken_count;
			out_q.sentence_ready  <= sent_stat.sentence_ready;
			out_q.sentence_length <= sent_stat.sentence_length;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	a_start_reaches_units: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == T_WAIT && line_stat.busy && sent_stat.busy)
		else $error("request accepted but store units not started");

endmodule
